// ===== hw/rtl/dpu_pkg.sv =====
// shared types and constants for the bitmap pixel unpack block
// no dependencies; imported by dpu_lookup and dib_pixel_unpack_mask_key
package dpu_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] OP_PIXEL    = 2'd0;
   localparam logic [1:0] OP_SRC_PAL  = 2'd1;
   localparam logic [1:0] OP_MASK_PAL = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] REG_SOURCE_DEPTH = 2'd0;
   localparam logic [1:0] REG_MASK_DEPTH   = 2'd1;
   localparam logic [1:0] REG_OPAQUE_MODE  = 2'd2;
   localparam logic [1:0] REG_USE_MASK     = 2'd3;

   // decoded pixel depths
   localparam logic [5:0] DEPTH_1  = 6'd1;
   localparam logic [5:0] DEPTH_4  = 6'd4;
   localparam logic [5:0] DEPTH_8  = 6'd8;
   localparam logic [5:0] DEPTH_24 = 6'd24;
   localparam logic [5:0] DEPTH_32 = 6'd32;

   localparam logic [5:0] SOURCE_DEPTH_RESET = DEPTH_8;
   localparam logic [5:0] MASK_DEPTH_RESET   = DEPTH_1;

   // mask pixel counts as solid when r+g+b is below this
   localparam logic [9:0] SOLID_LIMIT = 10'd384;
   localparam logic [7:0] ALPHA_SOLID = 8'hFF;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;

   typedef struct packed {
      logic supported;  // depth is one of 1, 4, 8, 24, 32
      logic direct;     // 24 or 32 bit bgr pixel, no palette
      logic key_zero;   // palettized pixel with index 0
   } decode_info_type;

endpackage

// ===== hw/rtl/dpu_lookup.sv =====
// pixel index extraction and palette memory with registered read
// depends on dpu_pkg
module dpu_lookup #(
   parameter int ENTRIES = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [5:0]               depth,
   input  logic [31:0]              word,
   input  logic [2:0]               subpixel,
   input  logic                     wr_en,
   input  logic [7:0]               wr_slot,
   input  logic [23:0]              wr_rgb,
   output logic [23:0]              rgb,
   output dpu_pkg::decode_info_type info
);
   import dpu_pkg::*;

   localparam int         AW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [8:0] ENTRY_LIMIT = 9'(ENTRIES);

   logic [23:0] pal_mem [ENTRIES];

   logic [7:0]      b0;
   logic [7:0]      idx;
   decode_info_type info_in;
   logic            idx_in_range;
   logic            wr_in_range;

   decode_info_type info_ff;
   logic            in_range_ff;
   logic [23:0]     direct_rgb_ff;
   logic [23:0]     ram_q_ff;

   assign b0 = word[7:0];

   always_comb begin
      idx     = 8'd0;
      info_in = '0;
      unique case (depth) inside
         DEPTH_1: begin
            idx               = {7'd0, b0[~subpixel]};
            info_in.supported = 1'b1;
         end
         DEPTH_4: begin
            idx               = subpixel[0] ? (b0 & NIBBLE_MASK) : {4'd0, b0[7:4]};
            info_in.supported = 1'b1;
         end
         DEPTH_8: begin
            idx               = b0;
            info_in.supported = 1'b1;
         end
         DEPTH_24, DEPTH_32: begin
            info_in.supported = 1'b1;
            info_in.direct    = 1'b1;
         end
         default: begin
            info_in.supported = 1'b0;
         end
      endcase
      info_in.key_zero = info_in.supported && !info_in.direct && (idx == 8'd0);
   end

   assign idx_in_range = ({1'b0, idx} < ENTRY_LIMIT);
   assign wr_in_range  = ({1'b0, wr_slot} < ENTRY_LIMIT);

   // palette writes and reads happen only on accepted requests
   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         pal_mem[wr_slot[AW-1:0]] <= wr_rgb;
      end
      if (load) begin
         ram_q_ff <= pal_mem[idx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         direct_rgb_ff <= word[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         info_ff     <= '0;
         in_range_ff <= 1'b0;
      end else if (load) begin
         info_ff     <= info_in;
         in_range_ff <= idx_in_range;
      end
   end

   // index beyond the palette reads as black
   assign rgb  = info_ff.direct ? direct_rgb_ff : (in_range_ff ? ram_q_ff : 24'd0);
   assign info = info_ff;

endmodule

// ===== hw/rtl/dib_pixel_unpack_mask_key.sv =====
// top level of the bitmap pixel unpack block with mask or colour key
// depends on dpu_pkg and dpu_lookup
//
// usage
//  - req channel carries one request per beat: a pixel, or a palette entry write
//    for the source or the mask palette (kind in req_tuser)
//  - palette writes give no result; each pixel request gives one rgba result on
//    the rsp channel, in request order; an unused kind is dropped
//  - csr port sets the source and mask depths, opaque mode and mask use; write
//    it only while no pixel is in flight
//  - pipeline: an accepted pixel loads the palette read register, then moves on to
//    the result register, which drives rsp_tvalid
//  - throughput: one request per cycle while rsp is not stalled, bounded by the
//    single read port of each palette memory
//  - reset: pipeline empties, registers return to depth 8, mask depth 1, mode
//    bits clear; palette contents stay undefined until written
//  - stall: the result holds on rsp while rsp_tready is low; the read stage can
//    still take one more request, after which req_tready drops
module dib_pixel_unpack_mask_key #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // low to high: source_word[31:0], source_subpixel[34:32], mask_word[66:35],
   // mask_subpixel[69:67], palette_slot[77:70], zero pad[79:78]
   input  logic [79:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // low to high: red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic [31:0] rsp_tdata,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dpu_pkg::*;

   // request fields
   logic [1:0]  operation;
   logic [31:0] source_word;
   logic [2:0]  source_subpixel;
   logic [31:0] mask_word;
   logic [2:0]  mask_subpixel;
   logic [7:0]  palette_slot;

   // configuration registers
   logic [5:0] source_depth_ff;
   logic [5:0] mask_depth_ff;
   logic       opaque_mode_ff;
   logic       use_mask_ff;
   logic       csr_write;

   // pipeline control
   logic req_accept;
   logic pixel_accept;
   logic out_load;
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;

   // decode results after the palette read
   logic [23:0]     src_rgb;
   logic [23:0]     mask_rgb;
   decode_info_type src_info;
   decode_info_type mask_info;
   logic [9:0]      mask_sum;
   logic            mask_solid;
   logic            solid;

   logic [31:0] result_in;
   logic [31:0] result_ff;

   assign operation       = req_tuser;
   assign source_word     = req_tdata[31:0];
   assign source_subpixel = req_tdata[34:32];
   assign mask_word       = req_tdata[66:35];
   assign mask_subpixel   = req_tdata[69:67];
   assign palette_slot    = req_tdata[77:70];

   //-----------------------------------------------------------------
   // register port: write on the access phase, pready tied high
   //-----------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_depth_ff <= SOURCE_DEPTH_RESET;
         mask_depth_ff   <= MASK_DEPTH_RESET;
         opaque_mode_ff  <= 1'b0;
         use_mask_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_SOURCE_DEPTH: source_depth_ff <= csr_pwdata[5:0];
            REG_MASK_DEPTH:   mask_depth_ff   <= csr_pwdata[5:0];
            REG_OPAQUE_MODE:  opaque_mode_ff  <= csr_pwdata[0];
            REG_USE_MASK:     use_mask_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SOURCE_DEPTH: csr_prdata = {26'd0, source_depth_ff};
         REG_MASK_DEPTH:   csr_prdata = {26'd0, mask_depth_ff};
         REG_OPAQUE_MODE:  csr_prdata = {31'd0, opaque_mode_ff};
         REG_USE_MASK:     csr_prdata = {31'd0, use_mask_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   //-----------------------------------------------------------------
   // two-stage pipeline: palette read stage, then result register
   // the read stage refills as soon as its contents move on
   //-----------------------------------------------------------------
   assign out_load     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || out_load;
   assign req_accept   = req_tvalid && req_tready;
   assign pixel_accept = req_accept && (operation == OP_PIXEL);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = pixel_accept;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // source pixel decode and palette
   dpu_lookup #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_src_lookup (
      .clock    (clock),
      .reset    (reset),
      .load     (pixel_accept),
      .depth    (source_depth_ff),
      .word     (source_word),
      .subpixel (source_subpixel),
      .wr_en    (req_accept && (operation == OP_SRC_PAL)),
      .wr_slot  (palette_slot),
      .wr_rgb   (source_word[23:0]),
      .rgb      (src_rgb),
      .info     (src_info)
   );

   // mask pixel decode and palette; the entry data also rides in source_word
   dpu_lookup #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_mask_lookup (
      .clock    (clock),
      .reset    (reset),
      .load     (pixel_accept),
      .depth    (mask_depth_ff),
      .word     (mask_word),
      .subpixel (mask_subpixel),
      .wr_en    (req_accept && (operation == OP_MASK_PAL)),
      .wr_slot  (palette_slot),
      .wr_rgb   (source_word[23:0]),
      .rgb      (mask_rgb),
      .info     (mask_info)
   );

   //-----------------------------------------------------------------
   // opacity: unsupported source never, else opaque mode, else mask brightness, else colour key
   //-----------------------------------------------------------------
   assign mask_sum   = {2'd0, mask_rgb[23:16]} + {2'd0, mask_rgb[15:8]}
                     + {2'd0, mask_rgb[7:0]};
   assign mask_solid = mask_info.supported && (mask_sum < SOLID_LIMIT);

   always_comb begin
      if (!src_info.supported) begin
         solid = 1'b0;
      end else if (opaque_mode_ff) begin
         solid = 1'b1;
      end else if (use_mask_ff) begin
         solid = mask_solid;
      end else begin
         // direct depths never match the key
         solid = !src_info.key_zero;
      end
   end

   // transparent or unsupported pixels come out all zero
   assign result_in = solid ? {ALPHA_SOLID, src_rgb[7:0], src_rgb[15:8], src_rgb[23:16]}
                            : 32'd0;

   always_ff @(posedge clock) begin
      if (out_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff;

endmodule

// ===== tb/dib_pixel_unpack_mask_key_test.sv =====
// self-checking testbench for dib_pixel_unpack_mask_key: palette and pixel requests in,
// rgba results out, predicted in-house and checked in order; csr read back after writes
// depends on dpu_pkg and the dib_pixel_unpack_mask_key rtl
module dib_pixel_unpack_mask_key_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dpu_pkg::*;

   localparam int PAL_ENTRIES   = 256;
   localparam int IDLE_LIMIT    = 5000;  // cycles with no handshake or register access
   localparam int MAX_SHOWN     = 10;
   localparam int PHASE_ITEMS   = 50;
   localparam int RANDOM_PHASES = 8;
   localparam int SETTLE_CYCLES = 4;     // two pipeline stages plus margin

   // request kind with no meaning, dropped by the block
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // fixed settings: {source_depth, mask_depth, opaque_mode, use_mask}
   localparam logic [13:0] FIXED_PHASES [16] = '{
      {DEPTH_1,  DEPTH_1,  1'b0, 1'b0},
      {DEPTH_4,  DEPTH_1,  1'b0, 1'b0},
      {DEPTH_8,  DEPTH_1,  1'b0, 1'b0},
      {DEPTH_24, DEPTH_1,  1'b0, 1'b0},
      {DEPTH_32, DEPTH_1,  1'b0, 1'b0},
      {6'd2,     DEPTH_1,  1'b0, 1'b0},   // unsupported source depth
      {6'd16,    DEPTH_1,  1'b1, 1'b0},   // unsupported source, opaque does not rescue it
      {DEPTH_8,  DEPTH_1,  1'b0, 1'b1},
      {DEPTH_8,  DEPTH_4,  1'b0, 1'b1},
      {DEPTH_1,  DEPTH_8,  1'b0, 1'b1},
      {DEPTH_4,  DEPTH_24, 1'b0, 1'b1},
      {DEPTH_24, DEPTH_32, 1'b0, 1'b1},
      {DEPTH_4,  6'd7,     1'b0, 1'b1},   // unsupported mask depth
      {DEPTH_32, 6'd31,    1'b1, 1'b1},   // opaque wins over the mask
      {DEPTH_1,  DEPTH_32, 1'b1, 1'b0},
      {DEPTH_32, DEPTH_8,  1'b0, 1'b1}
   };

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] src_word;
      logic [2:0]  src_sub;
      logic [31:0] mask_word;
      logic [2:0]  mask_sub;
      logic [7:0]  slot;
   } pixel_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dib_pixel_unpack_mask_key #(
      .PALETTE_ENTRIES(PAL_ENTRIES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   // predictor state: register copies and palette copies, updated on handshakes
   logic [5:0]  cfg_src_depth  = SOURCE_DEPTH_RESET;
   logic [5:0]  cfg_mask_depth = MASK_DEPTH_RESET;
   logic        cfg_opaque     = 1'b0;
   logic        cfg_use_mask   = 1'b0;
   logic [23:0] src_pal_copy  [PAL_ENTRIES];
   logic [23:0] mask_pal_copy [PAL_ENTRIES];

   // generator side: which palette slots have been queued for writing
   bit          src_slot_loaded  [PAL_ENTRIES];
   bit          mask_slot_loaded [PAL_ENTRIES];

   pixel_req_type req_pending_q [$];
   logic [31:0]   rgba_expect_q [$];
   pixel_req_type drv_item;
   int            mismatches = 0;
   string         field_names [4] = '{"red", "green", "blue", "alpha"};

   task automatic note_mismatch(input string what);
      if (mismatches < MAX_SHOWN) $display("mismatch: %s", what);
      mismatches++;
   endtask

   // palette index of a palettized depth; 0 for direct or unsupported depths
   function automatic bit palette_index(input logic [5:0] depth, input logic [31:0] word,
                                        input logic [2:0] sub, output logic [7:0] idx);
      logic [7:0] b0;
      bit         hit;
      b0  = word[7:0];
      idx = '0;
      hit = 1'b1;
      case (depth)
         DEPTH_1: idx = {7'd0, b0[3'd7 - sub]};
         DEPTH_4: idx = sub[0] ? (b0 & NIBBLE_MASK) : (b0 >> 4);
         DEPTH_8: idx = b0;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic bit is_direct(input logic [5:0] depth);
      return depth == DEPTH_24 || depth == DEPTH_32;
   endfunction

   // packed rgb, red high; returns 0 for an unsupported depth
   function automatic bit decode_rgb(input logic [5:0] depth, input logic [31:0] word,
                                     input logic [2:0] sub, input bit mask_side,
                                     output logic [23:0] rgb, output bit key_zero);
      logic [7:0] idx;
      bit         ok;
      rgb      = '0;
      key_zero = 1'b0;
      ok       = 1'b1;
      if (palette_index(depth, word, sub, idx)) begin
         // an index past the palette reads as black
         if (idx < PAL_ENTRIES) rgb = mask_side ? mask_pal_copy[idx] : src_pal_copy[idx];
         key_zero = (idx == 8'd0);
      end else if (is_direct(depth)) begin
         rgb = word[23:0];  // byte 2 red, byte 1 green, byte 0 blue
      end else begin
         ok = 1'b0;
      end
      return ok;
   endfunction

   // expected rsp_tdata for one pixel request under the current settings
   function automatic logic [31:0] unpack_pixel(input pixel_req_type item);
      logic [23:0] rgb, mrgb;
      logic [9:0]  msum;
      bit          key0, mkey0, solid;
      solid = 1'b0;
      if (!decode_rgb(cfg_src_depth, item.src_word, item.src_sub, 1'b0, rgb, key0)) begin
         solid = 1'b0;
      end else if (cfg_opaque) begin
         solid = 1'b1;
      end else if (cfg_use_mask) begin
         if (decode_rgb(cfg_mask_depth, item.mask_word, item.mask_sub, 1'b1, mrgb, mkey0)) begin
            msum  = {2'b00, mrgb[23:16]} + {2'b00, mrgb[15:8]} + {2'b00, mrgb[7:0]};
            solid = msum < SOLID_LIMIT;
         end
      end else begin
         solid = !key0;
      end
      if (solid) return {ALPHA_SOLID, rgb[7:0], rgb[15:8], rgb[23:16]};
      return 32'd0;
   endfunction

   // random colour, biased toward the mask threshold and the extremes
   function automatic logic [23:0] rand_rgb();
      int pick, target, r, g, lo, hi;
      pick = $urandom_range(0, 5);
      if (pick == 0) return 24'h000000;
      if (pick == 1) return 24'hFFFFFF;
      if (pick <= 3) return 24'($urandom);
      target = int'(SOLID_LIMIT) + $urandom_range(0, 4) - 2;
      r  = $urandom_range(0, 255);
      lo = (target - r - 255 > 0) ? target - r - 255 : 0;
      hi = (target - r < 255) ? target - r : 255;
      g  = $urandom_range(lo, hi);
      return {8'(r), 8'(g), 8'(target - r - g)};
   endfunction

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: w[7:0] = 8'h00;
         1: w[7:0] = 8'hFF;
         2: w = {8'($urandom), rand_rgb()};
         default: ;
      endcase
      return w;
   endfunction

   task automatic push_item(input pixel_req_type item);
      if (item.op == OP_SRC_PAL)  src_slot_loaded[item.slot]  = 1'b1;
      if (item.op == OP_MASK_PAL) mask_slot_loaded[item.slot] = 1'b1;
      req_pending_q.push_back(item);
   endtask

   task automatic push_palette(input logic [1:0] op, input logic [7:0] slot,
                               input logic [23:0] rgb);
      pixel_req_type item;
      item           = pixel_req_type'({$urandom, $urandom, $urandom});
      item.op        = op;
      item.slot      = slot;
      item.src_word  = {8'($urandom), rgb};
      push_item(item);
   endtask

   // a pixel's result never depends on an unloaded palette slot: load it first when needed
   task automatic push_pixel(input pixel_req_type item);
      logic [7:0] idx;
      bit         src_ok;
      item.op = OP_PIXEL;
      src_ok  = palette_index(cfg_src_depth, item.src_word, item.src_sub, idx);
      if (src_ok && !src_slot_loaded[idx]) push_palette(OP_SRC_PAL, idx, rand_rgb());
      src_ok = src_ok || is_direct(cfg_src_depth);
      if (src_ok && !cfg_opaque && cfg_use_mask &&
          palette_index(cfg_mask_depth, item.mask_word, item.mask_sub, idx) &&
          !mask_slot_loaded[idx])
         push_palette(OP_MASK_PAL, idx, rand_rgb());
      push_item(item);
   endtask

   task automatic push_random_items(input int count);
      pixel_req_type item;
      int            pick;
      for (int i = 0; i < count; i++) begin
         item = pixel_req_type'({$urandom, $urandom, $urandom});
         item.src_word  = rand_word();
         item.mask_word = rand_word();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            push_palette(OP_SRC_PAL, 8'($urandom), rand_rgb());
         end else if (pick < 15) begin
            push_palette(OP_MASK_PAL, 8'($urandom), rand_rgb());
         end else if (pick < 18) begin
            item.op = OP_UNUSED;
            push_item(item);
         end else begin
            push_pixel(item);
         end
      end
   endtask

   // apb write: setup cycle, then access until pready
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SOURCE_DEPTH: cfg_src_depth  = value[5:0];
         REG_MASK_DEPTH:   cfg_mask_depth = value[5:0];
         REG_OPAQUE_MODE:  cfg_opaque     = value[0];
         REG_USE_MASK:     cfg_use_mask   = value[0];
         default: ;
      endcase
   endtask

   task automatic csr_check(input logic [1:0] idx);
      logic [31:0] want;
      case (idx)
         REG_SOURCE_DEPTH: want = {26'd0, cfg_src_depth};
         REG_MASK_DEPTH:   want = {26'd0, cfg_mask_depth};
         REG_OPAQUE_MODE:  want = {31'd0, cfg_opaque};
         default:          want = {31'd0, cfg_use_mask};
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         note_mismatch($sformatf("csr reg %0d read %h, expected %h", idx, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [13:0] s);
      csr_write(REG_SOURCE_DEPTH, {26'd0, s[13:8]});
      csr_write(REG_MASK_DEPTH,   {26'd0, s[7:2]});
      csr_write(REG_OPAQUE_MODE,  {31'd0, s[1]});
      csr_write(REG_USE_MASK,     {31'd0, s[0]});
      for (int i = 0; i < 4; i++) csr_check(2'(i));
   endtask

   // wait for all requests sent and all results back, then let palette writes settle
   task automatic drain();
      while (req_pending_q.size() != 0 || req_tvalid || rgba_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [5:0] rand_depth();
      logic [5:0] pool [5] = '{DEPTH_1, DEPTH_4, DEPTH_8, DEPTH_24, DEPTH_32};
      if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 4)];
      return 6'($urandom_range(1, 32));
   endfunction

   // request driver: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      pixel_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
         end else if (req_pending_q.size() != 0) begin
            nxt = req_pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, nxt.slot, nxt.mask_sub, nxt.mask_word,
                           nxt.src_sub, nxt.src_word};
            req_tuser  <= nxt.op;
            drv_item   <= nxt;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver: switches among stall patterns every so often
   int stall_mode = 0;
   int mode_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left  <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && req_tvalid && req_tready) begin
         case (drv_item.op)
            OP_SRC_PAL:  if (drv_item.slot < PAL_ENTRIES)
                            src_pal_copy[drv_item.slot] = drv_item.src_word[23:0];
            OP_MASK_PAL: if (drv_item.slot < PAL_ENTRIES)
                            mask_pal_copy[drv_item.slot] = drv_item.src_word[23:0];
            OP_PIXEL:    rgba_expect_q.push_back(unpack_pixel(drv_item));
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rgba_expect_q.size() == 0) begin
            note_mismatch($sformatf("result %h with none expected", rsp_tdata));
         end else begin
            want = rgba_expect_q.pop_front();
            for (int f = 0; f < 4; f++)
               if (rsp_tdata[8*f +: 8] !== want[8*f +: 8])
                  note_mismatch($sformatf("%s got %h, expected %h (pixel %h vs %h)",
                                          field_names[f], rsp_tdata[8*f +: 8],
                                          want[8*f +: 8], rsp_tdata, want));
         end
      end
   end

   // watchdog: any handshake or register access counts as progress
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      pixel_req_type item;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers must read back their reset values
      for (int i = 0; i < 4; i++) csr_check(2'(i));

      // directed part at reset settings (8 bit source, colour key)
      push_palette(OP_SRC_PAL,  8'd0,   24'hFFFFFF);  // index 0 is keyed out anyway
      push_palette(OP_SRC_PAL,  8'd255, 24'hFFFFFF);
      push_palette(OP_SRC_PAL,  8'd1,   24'h123456);
      push_palette(OP_SRC_PAL,  8'd15,  24'h80FF01);
      push_palette(OP_MASK_PAL, 8'd0,   24'h808080);  // sum 384, just transparent
      push_palette(OP_MASK_PAL, 8'd1,   24'h7F8080);  // sum 383, just solid
      push_palette(OP_MASK_PAL, 8'd255, 24'hFFFFFF);
      push_palette(OP_MASK_PAL, 8'd15,  24'h000000);
      item = '0;
      push_pixel(item);                               // key index 0, transparent
      item.src_word = 32'hFFFFFF01;
      push_pixel(item);
      item = '1;
      push_pixel(item);                               // every data field at its top
      item.op = OP_UNUSED;
      push_item(item);                                // unused kind, no result
      item = '0;
      item.src_word = 32'h0000000F;
      item.mask_sub = 3'd7;
      push_pixel(item);
      item.src_word = 32'h000000FF;
      push_pixel(item);
      drain();

      // fixed settings then random ones, draining before each register change
      for (int p = 0; p < 16 + RANDOM_PHASES; p++) begin
         if (p < 16)
            apply_settings(FIXED_PHASES[p]);
         else
            apply_settings({rand_depth(), rand_depth(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))});
         push_random_items(PHASE_ITEMS);
         drain();
      end

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dpu_pkg.sv
hw/rtl/dpu_lookup.sv
hw/rtl/dib_pixel_unpack_mask_key.sv
tb/dib_pixel_unpack_mask_key_test.sv
